@@ hdl/lcm_unit_assert.svh @@
// Assertion macros for the LCM unit.
`ifndef LCM_UNIT_ASSERT_SVH
`define LCM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/lcm_pkg.sv @@
`default_nettype none

package lcm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } lcm_state_e;

endpackage

`default_nettype wire

@@ hdl/lcm_unit.sv @@
// LCM unit: least common multiple of two unsigned operands.
// Input channel: in_valid_i/in_ready_o carries first_operand_i and second_operand_i.
// Output channel: out_valid_o/out_ready_i carries multiple_result_o (twice the operand
// width, exact) and invalid_flag_o, set with a zero result when either operand is zero.
// One word is worked on at a time; in_ready_o is high only while the sequencer idles.
// A single adder/subtractor is shared by three phases: binary GCD (one shift, subtract
// or swap per cycle), restoring division of the first operand by the GCD, and
// shift-add multiply by the second operand.
// The next word may be accepted in the cycle in which output valid rises, but not
// before the previous word has reached the output register.
// A zero operand skips the arithmetic: the sequencer goes from idle straight to ST_OUT.
// The result sits in an output register, so the next word may be accepted while it
// waits; if the receiver stalls, a finished computation holds in its last state
// until the output register frees up.
// Reset clears the sequencer and the output valid; no word is pending after reset.

`default_nettype none
`include "lcm_unit_assert.svh"

module lcm_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [OPERAND_WIDTH-1:0]     first_operand_i,
  input  logic [OPERAND_WIDTH-1:0]     second_operand_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2*OPERAND_WIDTH-1:0]   multiple_result_o,
  output logic                         invalid_flag_o
);
  import lcm_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned RW = 2 * W;
  localparam int unsigned AW = RW + 1;
  localparam int unsigned CW = $clog2(W);
  localparam int unsigned KW = $clog2(W);

  lcm_state_e     state_q, state_d;
  logic [W-1:0]   opa_q, opa_d;
  logic [W-1:0]   opb_q, opb_d;
  logic [W-1:0]   ga_q, ga_d;
  logic [W-1:0]   gb_q, gb_d;
  logic [KW-1:0]  k_q, k_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [RW-1:0]  acc_q, acc_d;
  logic           inv_q, inv_d;
  logic [RW-1:0]  res_q, res_d;
  logic           out_inv_q, out_inv_d;
  logic           out_valid_q, out_valid_d;

  logic [AW-1:0]  alu_x, alu_y, alu_r;
  logic           alu_sub, alu_neg, alu_zero;

  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_GCD: begin
        alu_x   = AW'(ga_q);
        alu_y   = AW'(gb_q);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_x   = AW'({ga_q, opa_q[W-1]});
        alu_y   = AW'(gb_q);
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_x   = {acc_q, 1'b0};
        alu_y   = opa_q[W-1] ? AW'(opb_q) : '0;
        alu_sub = 1'b0;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_r    = alu_x + (alu_sub ? ~alu_y : alu_y) + AW'(alu_sub);
  assign alu_neg  = alu_r[AW-1];
  assign alu_zero = (alu_r == '0);

  always_comb begin
    state_d     = state_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    ga_d        = ga_q;
    gb_d        = gb_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    inv_d       = inv_q;
    res_d       = res_q;
    out_inv_d   = out_inv_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          opa_d = first_operand_i;
          opb_d = second_operand_i;
          ga_d  = first_operand_i;
          gb_d  = second_operand_i;
          k_d   = '0;
          if (first_operand_i == '0 || second_operand_i == '0) begin
            acc_d   = '0;
            inv_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            inv_d   = 1'b0;
            state_d = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        priority if (!ga_q[0] && !gb_q[0]) begin
          ga_d = ga_q >> 1;
          gb_d = gb_q >> 1;
          k_d  = k_q + KW'(1);
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (alu_zero) begin
          gb_d    = ga_q << k_q;
          ga_d    = '0;
          cnt_d   = CW'(W - 1);
          state_d = ST_DIV;
        end else if (alu_neg) begin
          ga_d = gb_q;
          gb_d = ga_q;
        end else begin
          ga_d = alu_r[W-1:0];
        end
      end
      ST_DIV: begin
        ga_d  = alu_neg ? {ga_q[W-2:0], opa_q[W-1]} : alu_r[W-1:0];
        opa_d = {opa_q[W-2:0], !alu_neg};
        if (cnt_q == '0) begin
          acc_d   = '0;
          cnt_d   = CW'(W - 1);
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_MUL: begin
        acc_d = alu_r[RW-1:0];
        opa_d = opa_q << 1;
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          res_d       = acc_q;
          out_inv_d   = inv_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q     <= opa_d;
    opb_q     <= opb_d;
    ga_q      <= ga_d;
    gb_q      <= gb_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    acc_q     <= acc_d;
    inv_q     <= inv_d;
    res_q     <= res_d;
    out_inv_q <= out_inv_d;
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign multiple_result_o = res_q;
  assign invalid_flag_o    = out_inv_q;

  `LCM_ASSERT_IMP(a_inv_zero, clk_i, rst_ni, out_valid_o && invalid_flag_o,
                  multiple_result_o == '0, "invalid word carries nonzero result")
  `LCM_ASSERT_IMP(a_gcd_nonzero, clk_i, rst_ni, state_q == ST_GCD,
                  ga_q != '0 && gb_q != '0, "gcd operand reached zero")
  `LCM_ASSERT_IMP(a_div_rem, clk_i, rst_ni, state_q == ST_DIV,
                  ga_q < gb_q, "remainder not below divisor")
  `LCM_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o,
                  state_q != ST_IDLE, "accepted word did not start work")

endmodule

`default_nettype wire
